/* src/brb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants of the byte ring buffer engine.
// ----------------------------------------------------------------------------
package brb_pkg;

	localparam int VAL_W = 11;

	typedef enum logic [2:0] {
		OP_WRITE    = 3'd0,
		OP_FORCE    = 3'd1,
		OP_READ     = 3'd2,
		OP_PEEK     = 3'd3,
		OP_DISCARD  = 3'd4,
		OP_FIND     = 3'd5,
		OP_CLEAR    = 3'd6,
		OP_NONE     = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		RS_OK       = 2'd0,
		RS_FULL     = 2'd1,
		RS_BADOFF   = 2'd2,
		RS_NOTFOUND = 2'd3
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_FIND,
		S_HOLD
	} state_t;

	localparam logic [1:0] CFG_SIZE    = 2'd0;
	localparam logic [1:0] CFG_PATTERN = 2'd1;
	localparam logic [1:0] CFG_PLEN    = 2'd2;

	localparam logic [31:0] PATTERN_RST = 32'h00FE_DCBA;
	localparam logic [2:0]  PLEN_RST    = 3'd3;

endpackage
`default_nettype wire

/* src/byte_ring_buffer_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_buffer_engine
// Byte ring buffer with configurable capacity, checked and forced writes,
// burst reads, peek, discard, clear and a pattern search.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  item      item_valid/item_ready, opcode, data_in,    in
//            amount, run_first
//  result    result_valid/result_ready, byte_out,       out
//            status, result_value, fill_level, last
//  config    cfg_we, cfg_index, cfg_data                in
//
//  Write, forced write, discard, clear and no-op complete as the word is taken.
//  Peek and a read burst of n bytes use one access of the single
//  byte memory read port per byte.
//  A search from offset a stops at a match or at the last stored byte.
//  Reset clears pointers, count and state; the byte memory is not cleared.
//  A stalled result holds the engine; no word is taken while one waits.
// ----------------------------------------------------------------------------
module byte_ring_buffer_engine #(
	parameter int DEPTH       = 1024,
	parameter int PATTERN_MAX = 4,
	parameter int READ_BURST  = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [2:0]  opcode,
	input  wire logic [7:0]  data_in,
	input  wire logic [10:0] amount,
	input  wire logic        run_first,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [7:0]       byte_out,
	output logic [1:0]       status,
	output logic [10:0]      result_value,
	output logic [10:0]      fill_level,
	output logic             last,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int VW       = brb_pkg::VAL_W;
	localparam int SW       = VW + 1;
	localparam int CAP_MAX  = (DEPTH < 2047) ? DEPTH : 2047;
	localparam int PW       = $clog2(CAP_MAX);
	localparam int CW       = $clog2(CAP_MAX + 1);
	localparam int SIZE_RST = (CAP_MAX < 1024) ? CAP_MAX : 1024;
	localparam int BW       = $clog2(READ_BURST + 1);
	localparam int PM_USE   = (PATTERN_MAX < 7) ? PATTERN_MAX : 7;
	localparam logic [2:0] PLEN_CAP = 3'(PM_USE);

	function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p,
			input logic [VW-1:0] n, input logic [CW-1:0] sz);
		logic [SW-1:0] s;
		s = SW'(p) + SW'(n);
		if (s >= SW'(sz)) begin
			s = s - SW'(sz);
		end
		return PW'(s);
	endfunction

	brb_pkg::state_t state_q, state_d;

	logic [CW-1:0]  size_q;
	logic [31:0]    pattern_q;
	logic [2:0]     plen_q;
	logic [2:0]     plen_eff;
	logic [VW-1:0]  size_wr;

	logic [PW-1:0]  rp_q, rp_d, wp_q, wp_d, addr_q, addr_d;
	logic [CW-1:0]  cnt_q, cnt_d, dat_q, dat_d, thr_q, thr_d;
	logic           rej_q, rej_d;
	logic [BW-1:0]  idx_q, idx_d, n_q, n_d;
	logic           peek_q, peek_d;
	logic [7:0]     win_q [PATTERN_MAX];
	logic [7:0]     win_nx [PATTERN_MAX];
	logic           pat_hit;
	logic [1:0]     hold_st_q, hold_st_d;
	logic [VW-1:0]  hold_val_q, hold_val_d;

	logic [7:0]     mem_q [CAP_MAX];
	logic [7:0]     rdata_q;
	logic           mem_we, mem_re;
	logic [PW-1:0]  raddr;

	logic           out_valid_q, out_load;
	logic [7:0]     byte_q, ob;
	logic [1:0]     status_q, ost;
	logic [VW-1:0]  value_q, ov;
	logic [VW-1:0]  fill_q;
	logic           last_q, olast;

	logic           out_free, item_fire;

	assign out_free  = !out_valid_q || result_ready;
	assign item_ready = (state_q == brb_pkg::S_IDLE) && out_free;
	assign item_fire = item_valid && item_ready;
	assign plen_eff  = (plen_q > PLEN_CAP) ? PLEN_CAP : plen_q;

	always_comb begin
		size_wr = cfg_data[VW-1:0];
		if (size_wr == '0) begin
			size_wr = VW'(1);
		end
		if (size_wr > VW'(CAP_MAX)) begin
			size_wr = VW'(CAP_MAX);
		end
	end

	always_comb begin
		win_nx[0] = rdata_q;
		for (int d = 1; d < PATTERN_MAX; d++) begin
			win_nx[d] = win_q[d-1];
		end
		pat_hit = 1'b1;
		for (int d = 0; d < PATTERN_MAX; d++) begin
			if (d < int'(plen_eff) && win_nx[d] != 8'(pattern_q >> (8 * d))) begin
				pat_hit = 1'b0;
			end
		end
	end

	always_comb begin
		logic [VW-1:0] n_rd;
		logic [VW-1:0] n_ds;
		logic [CW-1:0] free_sp;
		logic [PW-1:0] start;
		n_rd = amount;
		if (n_rd > VW'(cnt_q)) begin
			n_rd = VW'(cnt_q);
		end
		if (n_rd > VW'(READ_BURST)) begin
			n_rd = VW'(READ_BURST);
		end
		n_ds = (amount > VW'(cnt_q)) ? VW'(cnt_q) : amount;
		free_sp = size_q - cnt_q;
		start = wrap_add(rp_q, amount, size_q);

		state_d    = state_q;
		rp_d       = rp_q;
		wp_d       = wp_q;
		cnt_d      = cnt_q;
		rej_d      = rej_q;
		addr_d     = addr_q;
		idx_d      = idx_q;
		n_d        = n_q;
		peek_d     = peek_q;
		dat_d      = dat_q;
		thr_d      = thr_q;
		hold_st_d  = hold_st_q;
		hold_val_d = hold_val_q;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		raddr      = addr_q;
		out_load   = 1'b0;
		ob         = 8'h00;
		ost        = brb_pkg::RS_OK;
		ov         = '0;
		olast      = 1'b1;

		case (state_q)
			brb_pkg::S_IDLE: begin
				if (item_fire) begin
					case (brb_pkg::op_t'(opcode))
						brb_pkg::OP_WRITE: begin
							out_load = 1'b1;
							if (run_first) begin
								if (amount > VW'(free_sp)) begin
									rej_d = 1'b1;
									ost   = brb_pkg::RS_FULL;
								end else if (amount == '0) begin
									rej_d = 1'b1;
								end else begin
									rej_d  = 1'b0;
									mem_we = 1'b1;
									wp_d   = wrap_add(wp_q, VW'(1), size_q);
									cnt_d  = cnt_q + CW'(1);
									ov     = VW'(1);
								end
							end else if (rej_q || cnt_q >= size_q) begin
								ost = brb_pkg::RS_FULL;
							end else begin
								mem_we = 1'b1;
								wp_d   = wrap_add(wp_q, VW'(1), size_q);
								cnt_d  = cnt_q + CW'(1);
								ov     = VW'(1);
							end
						end
						brb_pkg::OP_FORCE: begin
							out_load = 1'b1;
							mem_we   = 1'b1;
							wp_d     = wrap_add(wp_q, VW'(1), size_q);
							ov       = VW'(1);
							if (cnt_q >= size_q) begin
								rp_d = wrap_add(rp_q, VW'(1), size_q);
							end else begin
								cnt_d = cnt_q + CW'(1);
							end
						end
						brb_pkg::OP_READ: begin
							if (n_rd == '0) begin
								out_load = 1'b1;
							end else begin
								mem_re  = 1'b1;
								raddr   = rp_q;
								addr_d  = wrap_add(rp_q, VW'(1), size_q);
								rp_d    = wrap_add(rp_q, n_rd, size_q);
								cnt_d   = cnt_q - CW'(n_rd);
								idx_d   = BW'(1);
								n_d     = BW'(n_rd);
								peek_d  = 1'b0;
								state_d = brb_pkg::S_READ;
							end
						end
						brb_pkg::OP_PEEK: begin
							if (amount >= VW'(cnt_q)) begin
								out_load = 1'b1;
								ost      = brb_pkg::RS_BADOFF;
							end else begin
								mem_re  = 1'b1;
								raddr   = start;
								idx_d   = BW'(1);
								n_d     = BW'(1);
								peek_d  = 1'b1;
								state_d = brb_pkg::S_READ;
							end
						end
						brb_pkg::OP_DISCARD: begin
							out_load = 1'b1;
							rp_d     = wrap_add(rp_q, n_ds, size_q);
							cnt_d    = cnt_q - CW'(n_ds);
							ov       = n_ds;
						end
						brb_pkg::OP_FIND: begin
							if (plen_eff == '0 || amount >= VW'(cnt_q)) begin
								out_load = 1'b1;
								ost      = brb_pkg::RS_BADOFF;
							end else if (SW'(cnt_q) < SW'(amount) + SW'(plen_eff)) begin
								out_load = 1'b1;
								ost      = brb_pkg::RS_NOTFOUND;
							end else begin
								mem_re  = 1'b1;
								raddr   = start;
								addr_d  = wrap_add(start, VW'(1), size_q);
								dat_d   = CW'(amount);
								thr_d   = CW'(amount + VW'(plen_eff) - VW'(1));
								state_d = brb_pkg::S_FIND;
							end
						end
						brb_pkg::OP_CLEAR: begin
							out_load = 1'b1;
							rp_d     = '0;
							wp_d     = '0;
							cnt_d    = '0;
							rej_d    = 1'b0;
						end
						brb_pkg::OP_NONE: begin
							out_load = 1'b1;
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			brb_pkg::S_READ: begin
				if (out_free) begin
					out_load = 1'b1;
					ob       = rdata_q;
					ov       = peek_q ? '0 : VW'(idx_q);
					olast    = (idx_q == n_q);
					if (idx_q == n_q) begin
						state_d = brb_pkg::S_IDLE;
					end else begin
						mem_re = 1'b1;
						addr_d = wrap_add(addr_q, VW'(1), size_q);
						idx_d  = idx_q + BW'(1);
					end
				end
			end
			brb_pkg::S_FIND: begin
				mem_re = 1'b1;
				addr_d = wrap_add(addr_q, VW'(1), size_q);
				dat_d  = dat_q + CW'(1);
				if (dat_q >= thr_q && pat_hit) begin
					hold_st_d  = brb_pkg::RS_OK;
					hold_val_d = VW'(dat_q) - VW'(plen_eff) + VW'(1);
					state_d    = brb_pkg::S_HOLD;
				end else if (dat_q == cnt_q - CW'(1)) begin
					hold_st_d  = brb_pkg::RS_NOTFOUND;
					hold_val_d = '0;
					state_d    = brb_pkg::S_HOLD;
				end
			end
			brb_pkg::S_HOLD: begin
				if (out_free) begin
					out_load = 1'b1;
					ost      = hold_st_q;
					ov       = hold_val_q;
					state_d  = brb_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = brb_pkg::S_IDLE;
			end
		endcase

		if (cfg_we && cfg_index == brb_pkg::CFG_SIZE) begin
			rp_d  = '0;
			wp_d  = '0;
			cnt_d = '0;
			rej_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= brb_pkg::S_IDLE;
			rp_q        <= '0;
			wp_q        <= '0;
			cnt_q       <= '0;
			rej_q       <= 1'b0;
			out_valid_q <= 1'b0;
			size_q      <= CW'(SIZE_RST);
			pattern_q   <= brb_pkg::PATTERN_RST;
			plen_q      <= brb_pkg::PLEN_RST;
		end else begin
			state_q <= state_d;
			rp_q    <= rp_d;
			wp_q    <= wp_d;
			cnt_q   <= cnt_d;
			rej_q   <= rej_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					brb_pkg::CFG_SIZE:    size_q    <= CW'(size_wr);
					brb_pkg::CFG_PATTERN: pattern_q <= cfg_data;
					brb_pkg::CFG_PLEN:    plen_q    <= cfg_data[2:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_q     <= addr_d;
		idx_q      <= idx_d;
		n_q        <= n_d;
		peek_q     <= peek_d;
		dat_q      <= dat_d;
		thr_q      <= thr_d;
		hold_st_q  <= hold_st_d;
		hold_val_q <= hold_val_d;
		if (state_q == brb_pkg::S_FIND) begin
			win_q <= win_nx;
		end
		if (out_load) begin
			byte_q   <= ob;
			status_q <= ost;
			value_q  <= ov;
			fill_q   <= VW'(cnt_d);
			last_q   <= olast;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wp_q] <= data_in;
		end
		if (mem_re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign result_valid = out_valid_q;
	assign byte_out     = byte_q;
	assign status       = status_q;
	assign result_value = value_q;
	assign fill_level   = fill_q;
	assign last         = last_q;

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= size_q)
		else $error("fill count above capacity");

	a_ptr_rng: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(rp_q) < size_q && CW'(wp_q) < size_q)
		else $error("pointer beyond wrap point");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		wrap_add(rp_q, VW'(cnt_q), size_q) == wp_q)
		else $error("pointers disagree with fill count");

	a_find_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == brb_pkg::S_FIND |-> dat_q < cnt_q)
		else $error("search ran past the stored bytes");

	a_read_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == brb_pkg::S_READ |-> idx_q != '0 && idx_q <= n_q)
		else $error("burst index out of range");

endmodule
`default_nettype wire
